@@ sv/cps_pkg.sv @@
package cps_pkg;

   localparam int RATE_W = 32;            // rate and quotient width
   localparam int DSR_W  = 5;             // divisor width (divider + 1, up to 16)
   localparam int CNT_W  = 6;             // divider step counter width

   localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(RATE_W - 1);

   localparam logic [11:0] MAX_PRESCALER = 12'h800;
   localparam logic [3:0]  MAX_DIVIDER   = 4'hF;
   localparam logic [3:0]  FIRST_DIVIDER = 4'h1;

   // prescaler index: 0 -> prescaler 0, k -> prescaler 1 << (k - 1)
   localparam logic [3:0]  PRE_IDX_NONE  = 4'd13;
   localparam logic [3:0]  PRE_IDX_ZERO  = 4'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

@@ sv/clock_prescaler_divider_search_top.sv @@
// Card clock prescaler/divider search.
// Request channel (req_*): one beat carries the requested card clock in hertz
// (an upper limit). Response channel (rsp_*): one beat per request with the
// chosen prescaler, divider, packed rate word and a no-fit flag in tuser.
// csr_we/csr_wdata load the source clock rate; write it only while idle.
// For each divider 1..15 a serial divider forms clk/(divider+1), and
// then a shift-and-compare scan walks the prescaler steps 0,1,2,4..2048 that
// could still beat the best pair so far (one step per cycle, at most 13).
// The search ends early once a pair at prescaler 0 is found.
// The search is shortest when the first divider fits at prescaler 0 and
// longest when it runs over all fifteen dividers; the result is then
// loaded into the response register.
// One request at a time: req_tready is high only while the engine is idle.
// The response sits in an output register, so a new request is taken while
// a finished response waits; if the receiver stalls and a second search
// completes, that search holds its result until the register frees up.
// Reset (synchronous, active high) clears the source clock rate to 0, the
// sequencer and the response valid.
module clock_prescaler_divider_search_top (
   input  logic        clock,
   input  logic        reset,
   // request: [31:0] target_rate
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // response: [11:0] prescaler_value, [15:12] divider_value, [31:16] rate_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // response: [0] no_fit
   output logic        rsp_tuser,
   // source clock rate register
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   cps_pkg::state_type          state_ff, state_in;
   logic [cps_pkg::RATE_W-1:0]  clk_rate_ff, clk_rate_in;
   logic [cps_pkg::RATE_W-1:0]  target_ff, target_in;
   logic [cps_pkg::RATE_W-1:0]  cand_ff, cand_in;     // quotient, shifted per step
   logic [3:0]                  d_ff, d_in;           // current divider
   logic [3:0]                  k_ff, k_in;           // current prescaler index
   logic [3:0]                  best_k_ff, best_k_in;
   logic [3:0]                  best_d_ff, best_d_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 rsp_data_ff, rsp_data_in;
   logic                        rsp_user_ff, rsp_user_in;

   logic                        div_start;
   logic                        div_done;
   logic [cps_pkg::RATE_W-1:0]  div_q;
   logic [cps_pkg::DSR_W-1:0]   divisor;

   logic                        no_fit;
   logic [11:0]                 pre_val;
   logic [3:0]                  div_val;
   logic                        load_rsp;

   // divisor follows the divider value being set up this cycle
   assign divisor = {1'b0, d_in} + 1'b1;

   cps_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clk_rate_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // result from the best pair; saturate when nothing fit
   always_comb begin
      no_fit = (best_k_ff == cps_pkg::PRE_IDX_NONE);
      if (no_fit) begin
         pre_val = cps_pkg::MAX_PRESCALER;
         div_val = cps_pkg::MAX_DIVIDER;
      end else begin
         pre_val = (best_k_ff == cps_pkg::PRE_IDX_ZERO) ? 12'd0
                 : (12'd1 << (best_k_ff - 4'd1));
         div_val = best_d_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clk_rate_in  = csr_we ? csr_wdata : clk_rate_ff;
      target_in    = target_ff;
      cand_in      = cand_ff;
      d_in         = d_ff;
      k_in         = k_ff;
      best_k_in    = best_k_ff;
      best_d_in    = best_d_ff;
      div_start    = 1'b0;
      load_rsp     = 1'b0;
      req_tready   = 1'b0;

      case (state_ff)
         cps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               target_in = req_tdata;
               d_in      = cps_pkg::FIRST_DIVIDER;
               best_k_in = cps_pkg::PRE_IDX_NONE;
               best_d_in = cps_pkg::MAX_DIVIDER;
               div_start = 1'b1;
               state_in  = cps_pkg::ST_DIVIDE;
            end
         end
         cps_pkg::ST_DIVIDE: begin
            if (div_done) begin
               cand_in  = div_q;
               k_in     = cps_pkg::PRE_IDX_ZERO;
               state_in = cps_pkg::ST_SCAN;
            end
         end
         cps_pkg::ST_SCAN: begin
            if (k_ff < best_k_ff && cand_ff > target_ff) begin
               // next prescaler step halves the rate again
               k_in    = k_ff + 4'd1;
               cand_in = cand_ff >> 1;
            end else begin
               if (k_ff < best_k_ff) begin
                  best_k_in = k_ff;
                  best_d_in = d_ff;
               end
               if (d_ff == cps_pkg::MAX_DIVIDER || best_k_in == cps_pkg::PRE_IDX_ZERO) begin
                  state_in = cps_pkg::ST_FINISH;
               end else begin
                  d_in      = d_ff + 4'd1;
                  div_start = 1'b1;
                  state_in  = cps_pkg::ST_DIVIDE;
               end
            end
         end
         cps_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = cps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cps_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {pre_val, div_val, div_val, pre_val};
         rsp_user_in  = no_fit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cps_pkg::ST_IDLE;
         clk_rate_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         best_k_ff    <= cps_pkg::PRE_IDX_NONE;
      end else begin
         state_ff     <= state_in;
         clk_rate_ff  <= clk_rate_in;
         rsp_valid_ff <= rsp_valid_in;
         best_k_ff    <= best_k_in;
      end
      target_ff   <= target_in;
      cand_ff     <= cand_in;
      d_ff        <= d_in;
      k_ff        <= k_in;
      best_d_ff   <= best_d_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // divider only finishes while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == cps_pkg::ST_DIVIDE)
      else $error("divider done outside divide state");

   // best prescaler index stays within the step range
   a_best_k_range: assert property (@(posedge clock) disable iff (reset)
      best_k_ff <= cps_pkg::PRE_IDX_NONE)
      else $error("best prescaler index out of range");

   // prescaler is zero or a single power of two
   a_pre_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(rsp_data_ff[11:0]))
      else $error("prescaler not zero or power of two");

   // saturated setting goes with the no-fit flag
   a_no_fit_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |->
         (rsp_data_ff[11:0] == cps_pkg::MAX_PRESCALER &&
          rsp_data_ff[15:12] == cps_pkg::MAX_DIVIDER))
      else $error("no-fit response without saturated setting");

   // a new response is only loaded into a free or draining register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten");

endmodule

@@ sv/cps_divider.sv @@
// Serial restoring divider: one quotient bit per cycle, small divisor.
module cps_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [cps_pkg::RATE_W-1:0]        dividend,
   input  logic [cps_pkg::DSR_W-1:0]         divisor,
   output logic                              done,
   output logic [cps_pkg::RATE_W-1:0]        quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [cps_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [cps_pkg::RATE_W-1:0]       shift_ff, shift_in;
   logic [cps_pkg::DSR_W-1:0]        rem_ff, rem_in;
   logic [cps_pkg::DSR_W-1:0]        dsr_ff, dsr_in;
   logic [cps_pkg::DSR_W:0]          trial;
   logic [cps_pkg::DSR_W:0]          diff;
   logic                             fits;

   assign trial = {rem_ff, shift_ff[cps_pkg::RATE_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         shift_in = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         shift_in = {shift_ff[cps_pkg::RATE_W-2:0], fits};
         rem_in   = fits ? diff[cps_pkg::DSR_W-1:0] : trial[cps_pkg::DSR_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == cps_pkg::DIV_LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

@@ bench/clock_prescaler_divider_search_top_tb.sv @@
module clock_prescaler_divider_search_top_tb;

   // One response beat, highest field first; the order is not that of rsp_tdata,
   // but the struct lines up with the concatenation below.
   typedef struct packed {
      logic [11:0] prescaler;
      logic [3:0]  divider;
      logic [15:0] rate_word;
      logic        no_fit;
   } clock_setting_type;

   // Directed stimulus: source clock in effect, request, and the answer
   // where it is obvious by inspection (typed = 1); other rows are predicted.
   typedef struct packed {
      logic [31:0]       source_hz;
      logic [31:0]       target;
      logic              typed;
      clock_setting_type want;
   } directed_row_type;

   // Answers that need no arithmetic.
   localparam clock_setting_type FIRST_PAIR =
      '{12'h000, cps_pkg::FIRST_DIVIDER, {12'h000, cps_pkg::FIRST_DIVIDER}, 1'b0};
   localparam clock_setting_type SECOND_DIVIDER =
      '{12'h000, 4'h2, 16'h0002, 1'b0};
   localparam clock_setting_type LAST_PAIR_FITS =
      '{cps_pkg::MAX_PRESCALER, cps_pkg::MAX_DIVIDER,
        {cps_pkg::MAX_PRESCALER, cps_pkg::MAX_DIVIDER}, 1'b0};
   localparam clock_setting_type SATURATED =
      '{cps_pkg::MAX_PRESCALER, cps_pkg::MAX_DIVIDER,
        {cps_pkg::MAX_PRESCALER, cps_pkg::MAX_DIVIDER}, 1'b1};

   localparam int DIRECTED_COUNT = 21;
   localparam int PHASE_COUNT    = 9;
   localparam int PHASE_BEATS    = 130;   // 9 x 130 random requests
   localparam int MAX_REPORTS    = 40;    // detailed mismatch reports

   // The source clock rate resets to 0, so the first rows run without a write.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // zero source clock: first pair always accepted
      '{32'h0000_0000, 32'h0000_0000, 1'b1, FIRST_PAIR},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, FIRST_PAIR},
      '{32'h0000_0000, 32'h8000_0000, 1'b1, FIRST_PAIR},
      // full-scale source clock: target extremes and the no-fit edge
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, SATURATED},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, FIRST_PAIR},
      '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, FIRST_PAIR},
      '{32'hFFFF_FFFF, 32'h7FFF_FFFE, 1'b1, SECOND_DIVIDER},
      '{32'hFFFF_FFFF, 32'h0000_FFFF, 1'b1, LAST_PAIR_FITS},
      '{32'hFFFF_FFFF, 32'h0000_FFFE, 1'b1, SATURATED},
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, SATURATED},
      '{32'hFFFF_FFFF, 32'h1000_0000, 1'b0, '0},
      // one hertz source: 1/2 rounds to zero
      '{32'h0000_0001, 32'h0000_0000, 1'b1, FIRST_PAIR},
      // typical card setup numbers
      '{32'd48_000_000, 32'd400_000, 1'b0, '0},
      '{32'd48_000_000, 32'd25_000_000, 1'b0, '0},
      '{32'd48_000_000, 32'd0, 1'b0, '0},
      '{32'd48_000_000, 32'd732, 1'b0, '0},
      '{32'd48_000_000, 32'd731, 1'b0, '0},
      '{32'd32, 32'd0, 1'b0, '0},
      '{32'd100_000_000, 32'd1_000_000, 1'b0, '0},
      '{32'd100_000_000, 32'd50_000_000, 1'b0, '0},
      '{32'h8000_0000, 32'h3FFF_FFFF, 1'b0, '0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [31:0] csr_wdata;

   logic [31:0]       source_clock_hz;     // our copy of the rate register
   clock_setting_type awaited_settings[$]; // oldest request first
   bit                idling_on;           // random gaps on both channels
   int                fail_count;
   int                requests_sent;
   int                responses_checked;
   int                no_fit_seen;
   int                prescaled_seen;
   int                rate_writes;

   clock_prescaler_divider_search_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Card clock for one pair: floor(src / (div+1)), then floor by 2*pre
   // when the prescaler is nonzero.
   function automatic logic [31:0] divided_rate(input logic [31:0] src,
                                                input logic [31:0] pre,
                                                input int unsigned div);
      logic [31:0] rate;
      rate = src / 32'(div + 1);
      if (pre != 0) rate = rate / (pre << 1);
      return rate;
   endfunction

   // Walk prescalers 0,1,2,4..2048 and, inside each, dividers 1..15; the
   // first pair at or below the target wins. Nothing fits -> saturate.
   function automatic clock_setting_type search_clock_setting(input logic [31:0] src,
                                                              input logic [31:0] target);
      clock_setting_type setting;
      logic [31:0]       pre;
      bit                found;
      setting = SATURATED;
      pre     = 0;
      found   = 1'b0;
      while (!found && pre <= 32'(cps_pkg::MAX_PRESCALER)) begin
         for (int unsigned div = 1; div <= cps_pkg::MAX_DIVIDER && !found; div++) begin
            if (divided_rate(src, pre, div) <= target) begin
               found             = 1'b1;
               setting.prescaler = pre[11:0];
               setting.divider   = div[3:0];
               setting.rate_word = {pre[11:0], div[3:0]};
               setting.no_fit    = 1'b0;
            end
         end
         if (!found) pre = (pre == 0) ? 32'd1 : pre << 1;
      end
      return setting;
   endfunction

   // Mostly targets sitting right at a reachable rate (one below, on, one
   // above), so the search stops at every prescaler step and divider.
   function automatic logic [31:0] pick_target(input logic [31:0] src);
      int unsigned kind;
      int unsigned step;
      logic [31:0] pre;
      kind = $urandom_range(0, 9);
      if (kind == 0) return $urandom;
      if (kind == 1) return $urandom_range(0, 255);
      if (kind == 9) return ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3))
                                                        : ~32'($urandom_range(0, 3));
      step = $urandom_range(0, 12);
      pre  = (step == 0) ? 32'd0 : 32'd1 << (step - 1);
      return divided_rate(src, pre, $urandom_range(1, 15)) + $urandom_range(0, 2) - 1;
   endfunction

   // One request beat. tvalid stays up after acceptance so back-to-back
   // beats need no extra edge; whoever comes next lowers it if needed.
   task automatic send_target(input logic [31:0] target,
                              input bit typed,
                              input clock_setting_type want);
      int gap;
      gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      if (gap != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= target;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      awaited_settings.push_back(typed ? want : search_clock_setting(source_clock_hz, target));
      requests_sent++;
   endtask

   // Rate register writes only once every response is back (engine idle).
   task automatic load_source_rate(input logic [31:0] rate_hz);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_settings.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= rate_hz;
      @(negedge clock);
      csr_we <= 1'b0;
      source_clock_hz = rate_hz;
      rate_writes++;
   endtask

   // Receiver backpressure: stall bursts between ready runs.
   initial begin : response_backpressure
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(1, 18);
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(0, 20)) @(negedge clock);
      end
   end

   // Scoreboard: every response beat against the oldest outstanding request.
   always @(posedge clock) begin : response_check
      clock_setting_type want;
      clock_setting_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[11:0], rsp_tdata[15:12], rsp_tdata[31:16], rsp_tuser};
         if (awaited_settings.size() == 0) begin
            fail_count++;
            $error("response beat with nothing outstanding: tdata=%h tuser=%b",
                   rsp_tdata, rsp_tuser);
         end else begin
            want = awaited_settings.pop_front();
            responses_checked++;
            if (want.no_fit) no_fit_seen++;
            if (want.prescaler != 0) prescaled_seen++;
            if (got != want) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  if (got.prescaler != want.prescaler)
                     $error("prescaler_value: expected %0d, got %0d",
                            want.prescaler, got.prescaler);
                  if (got.divider != want.divider)
                     $error("divider_value: expected %0d, got %0d",
                            want.divider, got.divider);
                  if (got.rate_word != want.rate_word)
                     $error("rate_word: expected %h, got %h", want.rate_word, got.rate_word);
                  if (got.no_fit != want.no_fit)
                     $error("no_fit: expected %0b, got %0b", want.no_fit, got.no_fit);
               end
            end
         end
      end
   end

   // Watchdog: allows several times the worst case of ~1200 beats, each with
   // a full-length search and the longest stall on both channels.
   initial begin : watchdog
      #60000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] phase_rate;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      source_clock_hz = '0;
      idling_on       = 1'b1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed rows; rate changes drain the engine first.
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].source_hz != source_clock_hz)
            load_source_rate(DIRECTED_ROWS[i].source_hz);
         send_target(DIRECTED_ROWS[i].target, DIRECTED_ROWS[i].typed,
                     DIRECTED_ROWS[i].want);
      end

      // Random phases, each under its own source clock; last one runs
      // with no idling on either side.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       phase_rate = 32'hFFFF_FFFF;
            2:       phase_rate = $urandom_range(10_000_000, 200_000_000);
            3:       phase_rate = 32'h0000_0000;
            4:       phase_rate = $urandom_range(1, 4095);
            6:       phase_rate = $urandom_range(1_000_000, 100_000_000);
            7:       phase_rate = 32'h8000_0000 | $urandom;
            default: phase_rate = $urandom;
         endcase
         idling_on = (phase != PHASE_COUNT - 1);
         load_source_rate(phase_rate);
         repeat (PHASE_BEATS) send_target(pick_target(source_clock_hz), 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_settings.size() != 0) @(posedge clock);
      // a full search's worth of quiet to catch stray beats
      repeat (800) @(posedge clock);

      $display("Searched %0d card clock requests under %0d source clock settings",
               requests_sent, rate_writes + 1);
      $display("%0d responses checked: %0d needed a prescaler, %0d had no fit",
               responses_checked, prescaled_seen, no_fit_seen);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/cps_pkg.sv
sv/cps_divider.sv
sv/clock_prescaler_divider_search_top.sv
bench/clock_prescaler_divider_search_top_tb.sv
